### rtl/bpj_pkg.sv
// Shared types and constants for the depth pixel back-projection block.
// Used by every module under rtl/; depends on nothing.
`default_nettype none

package bpj_pkg;

    // Register index codes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DEPTH_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y     = 3'd4;

    localparam int CFG_DATA_W = 24;
    localparam int RECIP_W    = 24;   // Q0.24 reciprocals
    localparam int CENTER_W   = 16;   // Q12.4 principal point
    localparam int PIX_W      = 12;
    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int MAG_W      = 16;   // |pixel*16 - center|
    localparam int Z_W        = 32;   // Q16.16
    localparam int COORD_W    = 32;   // signed Q16.16
    localparam int MZ_W       = MAG_W + Z_W;
    localparam int HALF_W     = MZ_W / 2;
    localparam int PP_W       = HALF_W + RECIP_W;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 120;

    // Register reset values
    localparam logic [RECIP_W-1:0]  RST_INV_DEPTH_SCALE = 24'd16777;
    localparam logic [CENTER_W-1:0] RST_CENTER_X        = 16'd5208;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y        = 16'd4056;
    localparam logic [RECIP_W-1:0]  RST_INV_FOCAL_X     = 24'd32388;
    localparam logic [RECIP_W-1:0]  RST_INV_FOCAL_Y     = 24'd32326;

    // Saturation limits
    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [RECIP_W-1:0]  inv_depth_scale;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [RECIP_W-1:0]  inv_focal_x;
        logic [RECIP_W-1:0]  inv_focal_y;
    } cfg_t;

    // Load enables of the pipeline stages behind stage 1
    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
    } stage_en_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } color_t;

endpackage

`default_nettype wire

### rtl/bpj_cfg.sv
// Configuration register file of the back-projection block.
// Depends on bpj_pkg.
`default_nettype none

module bpj_cfg
    import bpj_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode one write; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_INV_DEPTH_SCALE: cfg_next.inv_depth_scale = cfg_data[RECIP_W-1:0];
                CFG_CENTER_X:        cfg_next.center_x        = cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:        cfg_next.center_y        = cfg_data[CENTER_W-1:0];
                CFG_INV_FOCAL_X:     cfg_next.inv_focal_x     = cfg_data[RECIP_W-1:0];
                CFG_INV_FOCAL_Y:     cfg_next.inv_focal_y     = cfg_data[RECIP_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_depth_scale <= RST_INV_DEPTH_SCALE;
            cfg_reg.center_x        <= RST_CENTER_X;
            cfg_reg.center_y        <= RST_CENTER_Y;
            cfg_reg.inv_focal_x     <= RST_INV_FOCAL_X;
            cfg_reg.inv_focal_y     <= RST_INV_FOCAL_Y;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/bpj_front.sv
// Stage 1 of the pipeline: depth scaling to z and pixel offsets from the
// principal point. Depends on bpj_pkg.
`default_nettype none

module bpj_front
    import bpj_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en1,
    input  wire logic [PIX_W-1:0]   pixel_row,
    input  wire logic [PIX_W-1:0]   pixel_column,
    input  wire logic [DEPTH_W-1:0] depth_raw,
    input  wire cfg_t               cfg,
    output logic [Z_W-1:0]          z_s1,
    output logic [MAG_W-1:0]        mag_x_s1,
    output logic                    neg_x_s1,
    output logic [MAG_W-1:0]        mag_y_s1,
    output logic                    neg_y_s1
);

    logic [DEPTH_W+RECIP_W-1:0] zprod;
    logic [MAG_W-1:0]           pos_x;
    logic [MAG_W-1:0]           pos_y;
    logic                       neg_x_next;
    logic                       neg_y_next;
    logic [MAG_W-1:0]           mag_x_next;
    logic [MAG_W-1:0]           mag_y_next;

    logic [Z_W-1:0]   z_reg;
    logic [MAG_W-1:0] mag_x_reg;
    logic [MAG_W-1:0] mag_y_reg;
    logic             neg_x_reg;
    logic             neg_y_reg;

    // z = depth * scale, Q16.24 truncated to Q16.16
    assign zprod = (DEPTH_W+RECIP_W)'(depth_raw) * (DEPTH_W+RECIP_W)'(cfg.inv_depth_scale);

    // Signed Q12.4 offsets as sign and magnitude
    always_comb
    begin
        pos_x      = {pixel_column, 4'b0000};
        pos_y      = {pixel_row, 4'b0000};
        neg_x_next = pos_x < cfg.center_x;
        neg_y_next = pos_y < cfg.center_y;
        mag_x_next = neg_x_next ? (cfg.center_x - pos_x) : (pos_x - cfg.center_x);
        mag_y_next = neg_y_next ? (cfg.center_y - pos_y) : (pos_y - cfg.center_y);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            z_reg     <= zprod[DEPTH_W+RECIP_W-1:8];
            mag_x_reg <= mag_x_next;
            mag_y_reg <= mag_y_next;
            neg_x_reg <= neg_x_next;
            neg_y_reg <= neg_y_next;
        end
    end

    assign z_s1     = z_reg;
    assign mag_x_s1 = mag_x_reg;
    assign neg_x_s1 = neg_x_reg;
    assign mag_y_s1 = mag_y_reg;
    assign neg_y_s1 = neg_y_reg;

endmodule

`default_nettype wire

### rtl/bpj_axis.sv
// Stages 2 to 4 for one coordinate: offset times z, times the reciprocal
// focal length in two halves, then shift, sign and saturate. Depends on bpj_pkg.
`default_nettype none

module bpj_axis
    import bpj_pkg::*;
(
    input  wire logic               clk,
    input  wire stage_en_t          en,
    input  wire logic [MAG_W-1:0]   mag_s1,
    input  wire logic               neg_s1,
    input  wire logic [Z_W-1:0]     z_s1,
    input  wire logic [RECIP_W-1:0] inv_f,
    output logic [COORD_W-1:0]      coord
);

    logic [MZ_W-1:0]    mz_reg;
    logic               neg_s2_reg;
    logic [PP_W-1:0]    phi_reg;
    logic [PP_W-1:0]    plo_reg;
    logic               neg_s3_reg;
    logic [COORD_W-1:0] coord_reg;

    logic [PP_W:0]       sum;
    logic [PP_W-4:0]     mag_q;
    logic [COORD_W-1:0]  coord_next;

    // Stage 2: magnitude times z (16 x 32)
    always_ff @(posedge clk)
    begin
        if (en.en2)
        begin
            mz_reg     <= MZ_W'(mag_s1) * MZ_W'(z_s1);
            neg_s2_reg <= neg_s1;
        end
    end

    // Stage 3: two 24 x 24 partial products
    always_ff @(posedge clk)
    begin
        if (en.en3)
        begin
            phi_reg    <= PP_W'(mz_reg[MZ_W-1:HALF_W]) * PP_W'(inv_f);
            plo_reg    <= PP_W'(mz_reg[HALF_W-1:0]) * PP_W'(inv_f);
            neg_s3_reg <= neg_s2_reg;
        end
    end

    // Stage 4: (phi*2^24 + plo) >> 28; the low 24 bits of plo drop out
    always_comb
    begin
        sum   = {1'b0, phi_reg} + (PP_W+1)'(plo_reg[PP_W-1:HALF_W]);
        mag_q = sum[PP_W:4];
        if (neg_s3_reg)
        begin
            if (mag_q >= (PP_W-3)'(COORD_MIN))
                coord_next = COORD_MIN;
            else
                coord_next = COORD_W'(0) - mag_q[COORD_W-1:0];
        end
        else
        begin
            if (mag_q > (PP_W-3)'(COORD_MAX))
                coord_next = COORD_MAX;
            else
                coord_next = mag_q[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.en4)
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

`default_nettype wire

### rtl/depth_pixel_backprojection.sv
// Top level of the depth pixel back-projection block: stream ports, valid
// pipeline and the z/color side path. Depends on bpj_pkg, bpj_cfg, bpj_front, bpj_axis.
`default_nettype none

// Back-projects one RGB-D pixel per clock through a pinhole camera model into
// a colored point (x, y, z in Q16.16, x and y saturated). The pipeline has
// four register stages: depth scaling and offsets, offset times z, two
// half-width products with the reciprocal focal length, then sum, sign and
// saturation into the output register. An accepted item passes the stage 1 to 4
// registers in order, and its point is valid on the master side from stage 4; one
// item is taken every cycle while results are taken, and stage handshakes fill
// bubbles when the output stalls. Pixels with zero depth are accepted and give
// no point. The user must write registers through the configuration port only
// while the block is idle; the block itself does not enforce this.

module depth_pixel_backprojection
    import bpj_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // pixel_row[11:0], pixel_column[23:12], depth_raw[39:24],
    // blue_in[47:40], green_in[55:48], red_in[63:56]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // point output
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64],
    // blue_out[103:96], green_out[111:104], red_out[119:112]
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    cfg_t       cfg;
    stage_en_t  en;
    logic       en1;

    logic [PIX_W-1:0]   pixel_row;
    logic [PIX_W-1:0]   pixel_column;
    logic [DEPTH_W-1:0] depth_raw;
    color_t             color_in;

    logic [Z_W-1:0]   z_s1;
    logic [MAG_W-1:0] mag_x_s1;
    logic [MAG_W-1:0] mag_y_s1;
    logic             neg_x_s1;
    logic             neg_y_s1;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;

    logic [Z_W-1:0] z_s2_reg, z_s3_reg, z_s4_reg;
    color_t         col_s1_reg, col_s2_reg, col_s3_reg, col_s4_reg;

    // Unpack the input item; colors are red, green, blue from the top byte down
    assign pixel_row    = s_tdata[11:0];
    assign pixel_column = s_tdata[23:12];
    assign depth_raw    = s_tdata[39:24];
    assign color_in     = color_t'(s_tdata[63:40]);

    // A stage loads when it is empty or its successor loads
    always_comb
    begin
        en.en4 = !v4_reg || m_tready;
        en.en3 = !v3_reg || en.en4;
        en.en2 = !v2_reg || en.en3;
        en1    = !v1_reg || en.en2;
    end

    assign s_tready = en1;

    // Valid bits; zero depth enters as a bubble
    always_comb
    begin
        v1_next = en1    ? (s_tvalid && (depth_raw != '0)) : v1_reg;
        v2_next = en.en2 ? v1_reg : v2_reg;
        v3_next = en.en3 ? v2_reg : v3_reg;
        v4_next = en.en4 ? v3_reg : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // z and color side path
    always_ff @(posedge clk)
    begin
        if (en1)
            col_s1_reg <= color_in;
        if (en.en2)
        begin
            z_s2_reg   <= z_s1;
            col_s2_reg <= col_s1_reg;
        end
        if (en.en3)
        begin
            z_s3_reg   <= z_s2_reg;
            col_s3_reg <= col_s2_reg;
        end
        if (en.en4)
        begin
            z_s4_reg   <= z_s3_reg;
            col_s4_reg <= col_s3_reg;
        end
    end

    bpj_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpj_front u_front (
        .clk          (clk),
        .en1          (en1),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .depth_raw    (depth_raw),
        .cfg          (cfg),
        .z_s1         (z_s1),
        .mag_x_s1     (mag_x_s1),
        .neg_x_s1     (neg_x_s1),
        .mag_y_s1     (mag_y_s1),
        .neg_y_s1     (neg_y_s1)
    );

    bpj_axis u_axis_x (
        .clk    (clk),
        .en     (en),
        .mag_s1 (mag_x_s1),
        .neg_s1 (neg_x_s1),
        .z_s1   (z_s1),
        .inv_f  (cfg.inv_focal_x),
        .coord  (point_x)
    );

    bpj_axis u_axis_y (
        .clk    (clk),
        .en     (en),
        .mag_s1 (mag_y_s1),
        .neg_s1 (neg_y_s1),
        .z_s1   (z_s1),
        .inv_f  (cfg.inv_focal_y),
        .coord  (point_y)
    );

    // Output item
    assign m_tvalid = v4_reg;
    assign m_tdata  = {col_s4_reg.red, col_s4_reg.green, col_s4_reg.blue,
                       z_s4_reg, point_y, point_x};

endmodule

`default_nettype wire

### rtl/bpj_checker.sv
// Port-level assertions for depth_pixel_backprojection and the bind that
// attaches them. Depends on bpj_pkg and the top level.
`default_nettype none

module bpj_checker
    import bpj_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata
);

    // Stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    // An empty pipeline always takes input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A point at zero depth lies on the optical axis
    a_zero_z: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[95:64] == 32'd0) |-> (m_tdata[63:0] == 64'd0))
        else $error("nonzero x or y with z of zero");

    // With the sink ready, a valid pixel passes the stage registers and shows up on the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[39:24] != 16'd0)
        ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("point missing after pipeline latency");

endmodule

bind depth_pixel_backprojection bpj_checker u_bpj_checker (.*);

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for depth_pixel_backprojection: stream driver, monitor and a
// fixed-point back-projection predictor with its own copy of the camera registers.
// Depends on bpj_pkg and the RTL under rtl/.

module testbench;
    import bpj_pkg::*;

    localparam int DRAIN_CYCLES   = 10;    // pipeline is four stages deep
    localparam int LONG_HOLD      = 400;   // receiver hold-off for the fill-up phase
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all

    // Input item, packed as on s_tdata
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [DEPTH_W-1:0] depth;
        logic [PIX_W-1:0]   column;
        logic [PIX_W-1:0]   row;
    } pixel_t;

    // Result item, packed as on m_tdata
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [Z_W-1:0]     z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } point_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    cfg_t   camera_cfg;
    pixel_t pixel_queue [$];
    point_t expected_points [$];

    int     error_count = 0;
    int     src_gap_mode = 0;
    int     snk_gap_mode = 0;
    bit     long_hold_req = 1'b0;
    int     src_gap_left = 0;
    int     stall_left = 0;
    int     hold_left = 0;
    int     quiet_cycles = 0;

    string  field_names [6] = '{"point_x", "point_y", "point_z",
                                "blue_out", "green_out", "red_out"};

    depth_pixel_backprojection uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // One projected coordinate: |pixel*16 - center| * z * inv_f >> 28, sign, saturate
    function automatic logic [COORD_W-1:0] axis_coord(input logic [PIX_W-1:0] pix,
                                                      input logic [CENTER_W-1:0] center,
                                                      input logic [Z_W-1:0] z,
                                                      input logic [RECIP_W-1:0] inv_f);
        logic [15:0] pos;
        logic [15:0] mag;
        logic        neg;
        logic [79:0] prod;
        pos  = {pix, 4'b0000};
        neg  = pos < center;
        mag  = neg ? (center - pos) : (pos - center);
        prod = (80'(mag) * 80'(z) * 80'(inv_f)) >> 28;
        if (neg)
        begin
            if (prod >= 80'h8000_0000)
                return COORD_MIN;
            return -prod[COORD_W-1:0];
        end
        if (prod > 80'h7FFF_FFFF)
            return COORD_MAX;
        return prod[COORD_W-1:0];
    endfunction

    // Back-projects a pixel under the current camera registers; zero depth gives no point
    function automatic bit backproject(input pixel_t px, output point_t pt);
        logic [39:0] zfull;
        pt = '0;
        if (px.depth == '0)
            return 1'b0;
        zfull    = 40'(px.depth) * 40'(camera_cfg.inv_depth_scale);
        pt.z     = zfull[39:8];
        pt.x     = axis_coord(px.column, camera_cfg.center_x, pt.z, camera_cfg.inv_focal_x);
        pt.y     = axis_coord(px.row, camera_cfg.center_y, pt.z, camera_cfg.inv_focal_y);
        pt.blue  = px.blue;
        pt.green = px.green;
        pt.red   = px.red;
        return 1'b1;
    endfunction

    function automatic logic [31:0] field_of(input point_t pt, input int k);
        case (k)
            0: return pt.x;
            1: return pt.y;
            2: return pt.z;
            3: return 32'(pt.blue);
            4: return 32'(pt.green);
            default: return 32'(pt.red);
        endcase
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Pixel driver: pops the pending queue, predicts each accepted item
    always @(posedge clk)
    begin
        bit     offering;
        point_t pt;
        if (rst_n)
        begin
            offering = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                if (backproject(pixel_t'(s_tdata), pt))
                    expected_points = {expected_points, pt};
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (src_gap_left > 0)
                begin
                    src_gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pixel_queue.size() > 0)
                begin
                    s_tdata  <= pixel_queue.pop_front();
                    s_tvalid <= 1'b1;
                    if (src_gap_mode != 0)
                        src_gap_left = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Point monitor: checks against the oldest expectation, drives back-pressure
    always @(posedge clk)
    begin
        point_t got;
        point_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = point_t'(m_tdata);
                if (expected_points.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected point, expected none, got %h", $time, got);
                end
                else
                begin
                    want = expected_points.pop_front();
                    for (int k = 0; k < 6; k++)
                    begin
                        if (field_of(got, k) !== field_of(want, k))
                        begin
                            error_count++;
                            $display("%0t: %s expected %h got %h", $time, field_names[k],
                                     field_of(want, k), field_of(got, k));
                        end
                    end
                end
            end

            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (snk_gap_mode != 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_INV_DEPTH_SCALE: camera_cfg.inv_depth_scale = val;
            CFG_CENTER_X:        camera_cfg.center_x = val[CENTER_W-1:0];
            CFG_CENTER_Y:        camera_cfg.center_y = val[CENTER_W-1:0];
            CFG_INV_FOCAL_X:     camera_cfg.inv_focal_x = val;
            CFG_INV_FOCAL_Y:     camera_cfg.inv_focal_y = val;
            default: ;
        endcase
    endtask

    task automatic set_camera(input logic [23:0] ids, input logic [23:0] cx, input logic [23:0] cy,
                              input logic [23:0] fx, input logic [23:0] fy);
        write_reg(CFG_INV_DEPTH_SCALE, ids);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_INV_FOCAL_X, fx);
        write_reg(CFG_INV_FOCAL_Y, fy);
    endtask

    task automatic push_pixel(input int row, input int column, input int depth,
                              input int blue, input int green, input int red);
        pixel_t px;
        px.row    = row[PIX_W-1:0];
        px.column = column[PIX_W-1:0];
        px.depth  = depth[DEPTH_W-1:0];
        px.blue   = blue[7:0];
        px.green  = green[7:0];
        px.red    = red[7:0];
        pixel_queue = {pixel_queue, px};
    endtask

    function automatic int random_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        if (r < 16)
            return 4095;
        return $urandom_range(0, 4095);
    endfunction

    task automatic push_random_pixels(input int count);
        int r;
        int depth;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                depth = 0;
            else if (r < 20)
                depth = 65535;
            else if (r < 35)
                depth = $urandom_range(1, 255);
            else
                depth = $urandom_range(1, 65535);
            push_pixel(random_coord(), random_coord(), depth,
                       $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        end
    endtask

    // Register value: minimum, maximum or random within 24 bits
    function automatic logic [23:0] extreme_or_random();
        case ($urandom_range(0, 3))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_camera(input int style);
        case (style)
            0: set_camera(24'($urandom_range(1000, 70000)),
                          24'($urandom_range(0, 65535)) | (24'($urandom) << 16),
                          24'($urandom_range(0, 65535)), 24'($urandom_range(1, 1 << 18)),
                          24'($urandom_range(1, 1 << 18)));
            1: set_camera(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom));
            default: set_camera(extreme_or_random(), extreme_or_random(), extreme_or_random(),
                                extreme_or_random(), extreme_or_random());
        endcase
    endtask

    // Sender pauses until every point has come back and the pipeline is empty
    task automatic wait_idle();
        while (pixel_queue.size() != 0 || s_tvalid || expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        camera_cfg.inv_depth_scale = RST_INV_DEPTH_SCALE;
        camera_cfg.center_x        = RST_CENTER_X;
        camera_cfg.center_y        = RST_CENTER_Y;
        camera_cfg.inv_focal_x     = RST_INV_FOCAL_X;
        camera_cfg.inv_focal_y     = RST_INV_FOCAL_Y;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset camera: zero depth, corners, near the principal point, color extremes
        push_pixel(0, 0, 0, 0, 0, 0);
        push_pixel(0, 0, 1, 255, 255, 255);
        push_pixel(4095, 4095, 65535, 255, 0, 170);
        push_pixel(253, 325, 1000, 85, 170, 0);
        push_pixel(4095, 0, 65535, 1, 2, 3);
        push_pixel(0, 4095, 32768, 85, 85, 85);
        push_pixel(4095, 4095, 0, 255, 255, 255);
        wait_idle();

        // Largest scale and reciprocals with center at zero: positive saturation
        set_camera(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF);
        push_pixel(4095, 4095, 65535, 12, 34, 56);
        push_pixel(0, 0, 65535, 0, 255, 0);
        push_pixel(1, 1, 1, 255, 0, 255);
        push_pixel(2048, 2048, 0, 7, 7, 7);
        wait_idle();

        // Zero scale and reciprocals: z, x and y all zero but the point is emitted
        set_camera(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000);
        push_pixel(100, 200, 1234, 9, 8, 7);
        push_pixel(4095, 0, 65535, 255, 255, 255);
        wait_idle();

        // Center beyond the image: negative saturation and small negative offsets
        set_camera(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        push_pixel(0, 0, 65535, 1, 1, 1);
        push_pixel(4095, 4095, 65535, 2, 2, 2);
        push_pixel(4095, 4095, 1, 3, 3, 3);
        wait_idle();

        // Writes to unused indices must leave the camera untouched
        for (int k = int'(CFG_INV_FOCAL_Y) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), 24'($urandom));
        push_pixel(1000, 3000, 40000, 4, 5, 6);
        push_pixel(3000, 1000, 20000, 6, 5, 4);
        wait_idle();

        // Random phases over several cameras and idling patterns
        for (int phase = 0; phase < 8; phase++)
        begin
            random_camera(phase % 3);
            if (phase == 5)
            begin
                // Receiver holds off while the sender keeps offering back to back
                src_gap_mode = 0;
                snk_gap_mode = 1;
                push_random_pixels(200);
                long_hold_req = 1'b1;
            end
            else
            begin
                src_gap_mode = phase & 1;
                snk_gap_mode = (phase >> 1) & 1;
                push_random_pixels(155);
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
rtl/bpj_pkg.sv
rtl/bpj_cfg.sv
rtl/bpj_front.sv
rtl/bpj_axis.sv
rtl/depth_pixel_backprojection.sv
rtl/bpj_checker.sv
bench/testbench.sv
